/* src/assert_macros.svh */
// Assertion macros used by the port-level assertions of the compositor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent, checked at every rising edge outside reset.
`define ROC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compositor assertion failed");

// An expression that must hold at every rising edge outside reset.
`define ROC_ASSERT_HOLD(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("compositor assertion failed");

`endif

/* src/roc_pkg.sv */
// Types, codes and arithmetic helpers of the RGBA over compositor.
package roc_pkg;

    localparam int NUM_LANES  = 4;
    localparam int ALPHA_LANE = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0]  CHAN_MAX    = 8'd255;
    localparam logic [7:0]  ROUND_HALF  = 8'd127;
    // Reciprocal of 255 scaled by 2^25; exact for every value below 132625.
    localparam logic [17:0] RECIP_255   = 18'd131587;

    typedef struct packed {
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] mask_value;
    } t_req;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       written;
    } t_rsp;

    typedef enum logic [2:0] {
        MODE_COPY       = 3'd0,
        MODE_OVER       = 3'd1,
        MODE_FILL       = 3'd2,
        MODE_COLOR_OVER = 3'd3,
        MODE_MASKED     = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MODE  = 3'd0,
        CFG_RED   = 3'd1,
        CFG_GREEN = 3'd2,
        CFG_BLUE  = 3'd3,
        CFG_ALPHA = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_KEEP  = 2'd0,
        KIND_COPY  = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_BLEND = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OPND_SRC    = 2'd0,
        OPND_COLOR  = 2'd1,
        OPND_SCALED = 2'd2
    } t_opnd;

    typedef struct packed {
        t_kind kind;
        t_opnd opnd;
    } t_ctl;

    // Floor of x / 255 for any 17-bit x, by one multiplication.
    function automatic logic [9:0] div255(input logic [16:0] x);
        logic [34:0] prod;
        prod = {18'd0, x} * {17'd0, RECIP_255};
        return prod[34:25];
    endfunction

endpackage

/* src/roc_lane.sv */
// One colour channel of the compositor: mask scaling, blend and result select.
module roc_lane (
    input  logic          i_clk,
    input  logic [7:0]    i_dst,
    input  logic [7:0]    i_src,
    input  logic [7:0]    i_color,
    input  logic [7:0]    i_mask,
    input  logic [7:0]    i_alpha,
    input  roc_pkg::t_ctl i_ctl_s2,
    input  roc_pkg::t_ctl i_ctl_s3,
    output logic [7:0]    o_operand,
    output logic [7:0]    o_pixel
);
    import roc_pkg::*;

    logic [7:0]  r_d1, r_s1, r_d2, r_s2, r_c2, r_d3, r_s3, r_pix;
    logic [15:0] r_n1, n_n1;
    logic [16:0] r_n3, n_n3;
    logic [7:0]  n_c2, n_pix;
    logic [9:0]  q_scale, q_blend;
    logic [7:0]  inv_alpha;
    logic [16:0] dst_prod;

    // Stage 1: numerator of the colour scaled by the mask.
    assign n_n1 = ({8'd0, i_color} * {8'd0, i_mask}) + {8'd0, ROUND_HALF};

    // Stage 2: scaled colour, then choice of the blend operand.
    assign q_scale = div255({1'b0, r_n1});
    assign n_c2    = q_scale[7:0];

    always_comb begin
        case (i_ctl_s2.opnd)
            OPND_COLOR:  o_operand = i_color;
            OPND_SCALED: o_operand = r_c2;
            default:     o_operand = r_s2;
        endcase
    end

    // Stage 3: blend numerator s*255 + d*(255-a) + 127.
    assign inv_alpha = CHAN_MAX - i_alpha;
    assign dst_prod  = {9'd0, r_d2} * {9'd0, inv_alpha};
    assign n_n3      = ({1'b0, o_operand, 8'd0} - {9'd0, o_operand}) + dst_prod
                     + {9'd0, ROUND_HALF};

    // Stage 4: quotient with clamp, and the final pick of the channel.
    assign q_blend = div255(r_n3);

    always_comb begin
        case (i_ctl_s3.kind)
            KIND_COPY:  n_pix = r_s3;
            KIND_FILL:  n_pix = i_color;
            KIND_BLEND: n_pix = (q_blend > {2'd0, CHAN_MAX}) ? CHAN_MAX : q_blend[7:0];
            default:    n_pix = r_d3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_d1  <= i_dst;
        r_s1  <= i_src;
        r_n1  <= n_n1;
        r_d2  <= r_d1;
        r_s2  <= r_s1;
        r_c2  <= n_c2;
        r_d3  <= r_d2;
        r_s3  <= r_s2;
        r_n3  <= n_n3;
        r_pix <= n_pix;
    end

    assign o_pixel = r_pix;

endmodule

/* src/rgba_over_compositor.sv */
// Top level of the premultiplied RGBA8 over compositor with four channel lanes.
//
//   Channel   Direction  Handshake              Payload
//   request   in         start high, busy low   i_req (destination, source, mask)
//   result    out        o_done for one cycle   o_rsp (pixel and written flag)
//   config    in         i_cfg_wr_en            i_cfg_index, i_cfg_data
//
// A request is taken every cycle; busy stays low. Each result is computed in
// a pipeline after its request: mask multiply, divide by 255, blend multiply and
// divide by 255 with clamp, one pipeline stage each, in all four lanes at once.
// Reset is synchronous and clears the valid pipeline and the configuration registers.
// The receiver cannot stall, so the pipeline never holds.
module rgba_over_compositor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  roc_pkg::t_req                     i_req,
    output logic                              o_done,
    output roc_pkg::t_rsp                     o_rsp,
    input  logic                              i_cfg_wr_en,
    input  logic [roc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [roc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import roc_pkg::*;

    logic [2:0] r_mode;
    logic [7:0] r_color [NUM_LANES];
    logic [3:0] r_vld, n_vld;
    logic [3:0] r_wr, n_wr;
    t_ctl       r_ctl1, r_ctl2, r_ctl3, n_ctl;
    logic       accept;

    logic [7:0] dst_lane [NUM_LANES];
    logic [7:0] src_lane [NUM_LANES];
    logic [7:0] opnd_lane [NUM_LANES];
    logic [7:0] pix_lane [NUM_LANES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OVER;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_color[i] <= 8'd0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:  r_mode     <= i_cfg_data[2:0];
                CFG_RED:   r_color[0] <= i_cfg_data;
                CFG_GREEN: r_color[1] <= i_cfg_data;
                CFG_BLUE:  r_color[2] <= i_cfg_data;
                CFG_ALPHA: r_color[3] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Decide per request what the lanes produce; undefined modes keep the destination.
    always_comb begin
        n_ctl.kind = KIND_KEEP;
        n_ctl.opnd = OPND_SRC;
        unique case (t_mode'(r_mode))
            MODE_COPY: n_ctl.kind = KIND_COPY;
            MODE_OVER: begin
                if (i_req.src_alpha != 8'd0) begin
                    n_ctl.kind = KIND_BLEND;
                end
            end
            MODE_FILL: n_ctl.kind = KIND_FILL;
            MODE_COLOR_OVER: begin
                if (r_color[ALPHA_LANE] != 8'd0) begin
                    n_ctl.kind = KIND_BLEND;
                    n_ctl.opnd = OPND_COLOR;
                end
            end
            MODE_MASKED: begin
                if (r_color[ALPHA_LANE] != 8'd0 && i_req.mask_value != 8'd0) begin
                    n_ctl.kind = KIND_BLEND;
                    n_ctl.opnd = OPND_SCALED;
                end
            end
            default: ;
        endcase
    end

    assign n_vld = {r_vld[2:0], accept};
    assign n_wr  = {r_wr[2:0], n_ctl.kind != KIND_KEEP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr   <= n_wr;
        r_ctl1 <= n_ctl;
        r_ctl2 <= r_ctl1;
        r_ctl3 <= r_ctl2;
    end

    assign dst_lane[0] = i_req.dst_red;
    assign dst_lane[1] = i_req.dst_green;
    assign dst_lane[2] = i_req.dst_blue;
    assign dst_lane[3] = i_req.dst_alpha;
    assign src_lane[0] = i_req.src_red;
    assign src_lane[1] = i_req.src_green;
    assign src_lane[2] = i_req.src_blue;
    assign src_lane[3] = i_req.src_alpha;

    // The alpha lane's operand is the blend alpha for every lane.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        roc_lane u_lane (
            .i_clk     (i_clk),
            .i_dst     (dst_lane[g]),
            .i_src     (src_lane[g]),
            .i_color   (r_color[g]),
            .i_mask    (i_req.mask_value),
            .i_alpha   (opnd_lane[ALPHA_LANE]),
            .i_ctl_s2  (r_ctl2),
            .i_ctl_s3  (r_ctl3),
            .o_operand (opnd_lane[g]),
            .o_pixel   (pix_lane[g])
        );
    end

    assign o_done          = r_vld[3];
    assign o_rsp.out_red   = pix_lane[0];
    assign o_rsp.out_green = pix_lane[1];
    assign o_rsp.out_blue  = pix_lane[2];
    assign o_rsp.out_alpha = pix_lane[3];
    assign o_rsp.written   = r_wr[3];

endmodule

/* src/roc_assert.sv */
// Port-level assertions of the compositor and their bind to the top level.
`include "assert_macros.svh"

module roc_assert (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input roc_pkg::t_req i_req,
    input logic          o_done,
    input roc_pkg::t_rsp o_rsp
);
    import roc_pkg::*;

    logic        keep_out;
    logic [31:0] rsp_pixel;
    logic [31:0] req_dst;

    assign keep_out  = o_done && !o_rsp.written;
    assign rsp_pixel = {o_rsp.out_red, o_rsp.out_green, o_rsp.out_blue, o_rsp.out_alpha};
    assign req_dst   = {i_req.dst_red, i_req.dst_green, i_req.dst_blue, i_req.dst_alpha};

    // Every accepted request yields its result strobe.
    `ROC_ASSERT_IMP(a_req_gives_result, i_clk, i_rst_n, start && !busy, ##4 o_done)

    // No result appears without an earlier accepted request.
    `ROC_ASSERT_IMP(a_result_has_req, i_clk, i_rst_n, o_done, $past(start && !busy, 4))

    // An unwritten result carries the destination pixel unchanged.
    `ROC_ASSERT_IMP(a_keep_is_dst, i_clk, i_rst_n, keep_out, rsp_pixel == $past(req_dst, 4))

    // The pipeline takes a request in every cycle.
    `ROC_ASSERT_HOLD(a_never_busy, i_clk, i_rst_n, !busy)

endmodule

bind rgba_over_compositor roc_assert u_roc_assert (.*);

/* tb/tb_rgba_over_compositor.sv */
// Self-checking testbench for the premultiplied RGBA8 over compositor.
module tb_rgba_over_compositor;
    import roc_pkg::*;

    localparam int PIPE_DEPTH     = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_PIXELS   = 100;

    typedef struct {
        logic       is_write;
        logic [2:0] reg_idx;
        logic [7:0] reg_val;
        t_req       px;
        logic       no_gap;
    } t_op;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          start       = 1'b0;
    t_req          i_req       = '0;
    logic          i_cfg_wr_en = 1'b0;
    logic [2:0]    i_cfg_index = '0;
    logic [7:0]    i_cfg_data  = '0;
    logic          busy;
    logic          o_done;
    t_rsp          o_rsp;

    // Local copy of the register file, updated as writes land.
    logic [2:0]    reg_mode  = MODE_OVER;
    logic [7:0]    reg_color [4] = '{8'd0, 8'd0, 8'd0, 8'd0};

    t_op           pending_ops[$];
    t_rsp          expected_pixels[$];
    int            errors      = 0;
    int            idle_cycles = 0;
    int            n_pixels    = 0;
    int            n_writes    = 0;
    int            n_written   = 0;
    int            mode_hits [8] = '{default: 0};

    rgba_over_compositor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] blend_lane(input logic [7:0] d, input logic [7:0] s,
                                              input logic [7:0] a);
        int unsigned v;
        v = (int'(s) * 255 + int'(d) * (255 - int'(a)) + 127) / 255;
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [7:0] coverage_scale(input logic [7:0] c, input logic [7:0] m);
        int unsigned v;
        v = (int'(c) * int'(m) + 127) / 255;
        return v[7:0];
    endfunction

    function automatic t_rsp composite_pixel(input t_req r);
        logic [7:0] dst [4];
        logic [7:0] src [4];
        logic [7:0] tint [4];
        logic [7:0] pix [4];
        logic       wr;
        dst = '{r.dst_red, r.dst_green, r.dst_blue, r.dst_alpha};
        src = '{r.src_red, r.src_green, r.src_blue, r.src_alpha};
        pix = dst;
        wr  = 1'b0;
        case (reg_mode)
            MODE_COPY: begin
                pix = src;
                wr  = 1'b1;
            end
            MODE_OVER: begin
                if (src[ALPHA_LANE] == CHAN_MAX) begin
                    pix = src;
                    wr  = 1'b1;
                end else if (src[ALPHA_LANE] != 8'd0) begin
                    for (int i = 0; i < NUM_LANES; i++)
                        pix[i] = blend_lane(dst[i], src[i], src[ALPHA_LANE]);
                    wr = 1'b1;
                end
            end
            MODE_FILL: begin
                pix = reg_color;
                wr  = 1'b1;
            end
            MODE_COLOR_OVER: begin
                if (reg_color[ALPHA_LANE] == CHAN_MAX) begin
                    pix = reg_color;
                    wr  = 1'b1;
                end else if (reg_color[ALPHA_LANE] != 8'd0) begin
                    for (int i = 0; i < NUM_LANES; i++)
                        pix[i] = blend_lane(dst[i], reg_color[i], reg_color[ALPHA_LANE]);
                    wr = 1'b1;
                end
            end
            MODE_MASKED: begin
                if (reg_color[ALPHA_LANE] != 8'd0 && r.mask_value != 8'd0) begin
                    for (int i = 0; i < NUM_LANES; i++)
                        tint[i] = coverage_scale(reg_color[i], r.mask_value);
                    for (int i = 0; i < NUM_LANES; i++)
                        pix[i] = blend_lane(dst[i], tint[i], tint[ALPHA_LANE]);
                    wr = 1'b1;
                end
            end
            default: ;
        endcase
        return '{out_red: pix[0], out_green: pix[1], out_blue: pix[2], out_alpha: pix[3],
                 written: wr};
    endfunction

    function automatic void apply_reg_write(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            CFG_MODE:  reg_mode     = val[2:0];
            CFG_RED:   reg_color[0] = val;
            CFG_GREEN: reg_color[1] = val;
            CFG_BLUE:  reg_color[2] = val;
            CFG_ALPHA: reg_color[3] = val;
            default: ;
        endcase
    endfunction

    function automatic void queue_pixel(input t_req px, input logic no_gap);
        t_op op;
        op = '{is_write: 1'b0, reg_idx: '0, reg_val: '0, px: px, no_gap: no_gap};
        pending_ops.push_back(op);
    endfunction

    function automatic void queue_reg_write(input logic [2:0] idx, input logic [7:0] val);
        t_op op;
        op = '{is_write: 1'b1, reg_idx: idx, reg_val: val, px: '0, no_gap: 1'b0};
        pending_ops.push_back(op);
    endfunction

    function automatic void queue_color(input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue, input logic [7:0] alpha);
        queue_reg_write(CFG_RED, red);
        queue_reg_write(CFG_GREEN, green);
        queue_reg_write(CFG_BLUE, blue);
        queue_reg_write(CFG_ALPHA, alpha);
    endfunction

    function automatic t_req make_req(input logic [7:0] dr, input logic [7:0] dg,
                                      input logic [7:0] db, input logic [7:0] da,
                                      input logic [7:0] sr, input logic [7:0] sg,
                                      input logic [7:0] sb, input logic [7:0] sa,
                                      input logic [7:0] m);
        return '{dst_red: dr, dst_green: dg, dst_blue: db, dst_alpha: da,
                 src_red: sr, src_green: sg, src_blue: sb, src_alpha: sa, mask_value: m};
    endfunction

    // Zero and full scale turn up far more often than a flat draw would give them.
    function automatic logic [7:0] skewed_byte();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return CHAN_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_req random_req();
        return make_req(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), skewed_byte(),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), skewed_byte(), skewed_byte());
    endfunction

    // Request and register-write driver.
    always @(posedge i_clk) begin
        logic next_start;
        logic next_wr;
        next_start = 1'b0;
        next_wr    = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                mode_hits[reg_mode]++;
                expected_pixels.push_back(composite_pixel(i_req));
                void'(pending_ops.pop_front());
                n_pixels++;
            end
            if (i_cfg_wr_en)
                apply_reg_write(i_cfg_index, i_cfg_data);

            if (start && busy) begin
                next_start = 1'b1;
            end else if (pending_ops.size() != 0) begin
                if (pending_ops[0].is_write) begin
                    // Registers change only once the pipeline has drained.
                    if (expected_pixels.size() == 0) begin
                        next_wr = 1'b1;
                        i_cfg_index <= pending_ops[0].reg_idx;
                        i_cfg_data  <= pending_ops[0].reg_val;
                        void'(pending_ops.pop_front());
                        n_writes++;
                    end
                end else if (pending_ops[0].no_gap || $urandom_range(0, 99) >= 32) begin
                    next_start = 1'b1;
                    i_req <= pending_ops[0].px;
                end
            end
        end
        start       <= next_start;
        i_cfg_wr_en <= next_wr;
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result monitor: every strobe must match the oldest outstanding pixel.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_pixels.size() == 0) begin
                $error("result strobe with no request outstanding");
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_red", want.out_red, o_rsp.out_red);
                check_field("out_green", want.out_green, o_rsp.out_green);
                check_field("out_blue", want.out_blue, o_rsp.out_blue);
                check_field("out_alpha", want.out_alpha, o_rsp.out_alpha);
                check_field("written", 8'(want.written), 8'(o_rsp.written));
                if (want.written)
                    n_written++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        logic [2:0] mode;
        int         pick;
        logic       timed_out;

        // Reset state: source over, transparent black colour.
        queue_pixel(make_req(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, CHAN_MAX, 8'd0),
                    1'b0);
        queue_pixel(make_req(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd0, 8'd0), 1'b0);
        queue_pixel(make_req(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX,
                             CHAN_MAX, CHAN_MAX, CHAN_MAX, 8'd128, 8'd0), 1'b0);
        queue_pixel(make_req(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0), 1'b0);
        queue_pixel(make_req(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX,
                             CHAN_MAX, CHAN_MAX, CHAN_MAX), 1'b0);

        queue_reg_write(CFG_MODE, 8'(MODE_COPY));
        queue_pixel(make_req(8'd1, 8'd2, 8'd3, 8'd4, 8'd9, 8'd8, 8'd7, 8'd0, 8'd0), 1'b0);

        queue_color(8'h12, 8'h34, 8'h56, 8'h78);
        queue_reg_write(CFG_MODE, 8'(MODE_FILL));
        queue_pixel(random_req(), 1'b0);

        queue_reg_write(CFG_MODE, 8'(MODE_COLOR_OVER));
        queue_pixel(make_req(8'd90, 8'd80, 8'd70, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
        // Colour channel above its alpha, so the blend saturates.
        queue_reg_write(CFG_RED, 8'd200);
        queue_pixel(make_req(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, 8'd0, 8'd0, 8'd0, 8'd0,
                             8'd0), 1'b0);
        queue_reg_write(CFG_ALPHA, CHAN_MAX);
        queue_pixel(random_req(), 1'b0);
        queue_reg_write(CFG_ALPHA, 8'd0);
        queue_pixel(random_req(), 1'b0);

        queue_reg_write(CFG_MODE, 8'(MODE_MASKED));
        queue_pixel(make_req(8'd5, 8'd6, 8'd7, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, CHAN_MAX), 1'b0);
        queue_color(8'd150, 8'd60, 8'd255, 8'd200);
        queue_pixel(make_req(8'd5, 8'd6, 8'd7, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
        queue_pixel(make_req(8'd5, 8'd6, 8'd7, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1), 1'b0);
        queue_pixel(make_req(8'd99, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128), 1'b0);
        queue_pixel(make_req(8'd99, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, CHAN_MAX),
                    1'b0);
        queue_color(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
        queue_pixel(make_req(8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, CHAN_MAX), 1'b0);

        for (int u = MODE_MASKED + 1; u < 8; u++) begin
            queue_reg_write(CFG_MODE, 8'(u));
            queue_pixel(random_req(), 1'b0);
        end

        // Writes to unused register slots must leave the colour alone.
        queue_reg_write(CFG_MODE, 8'(MODE_MASKED));
        queue_color(8'd40, 8'd80, 8'd120, 8'd160);
        for (int k = CFG_ALPHA + 1; k < 8; k++)
            queue_reg_write(3'(k), CHAN_MAX);
        queue_pixel(make_req(8'd200, 8'd100, 8'd50, 8'd250, 8'd0, 8'd0, 8'd0, 8'd0, 8'd100),
                    1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = $urandom_range(0, 19);
            if (pick < 17)
                mode = 3'(pick % (MODE_MASKED + 1));
            else
                mode = 3'(MODE_MASKED + 1 + pick - 17);
            queue_reg_write(CFG_MODE, 8'(mode));
            queue_color(8'($urandom_range(0, 255)), skewed_byte(), skewed_byte(),
                        skewed_byte());
            if ($urandom_range(0, 3) == 0)
                queue_reg_write(3'($urandom_range(CFG_ALPHA + 1, 7)),
                                8'($urandom_range(0, 255)));
            // Two phases run back to back with no gaps between requests.
            for (int i = 0; i < PHASE_PIXELS; i++)
                queue_pixel(random_req(), ph == 4 || ph == 5);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pending_ops.size() != 0 || expected_pixels.size() != 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        timed_out = (idle_cycles >= WATCHDOG_LIMIT);
        if (!timed_out)
            repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (timed_out)
            $display("Run halted: no handshake for %0d cycles.", WATCHDOG_LIMIT);
        else if (expected_pixels.size() != 0) begin
            $error("%0d results never arrived", expected_pixels.size());
            errors++;
        end
        $display("Checked %0d pixels after %0d register writes; %0d wrote the destination.",
                 n_pixels, n_writes, n_written);
        $display("Pixels per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", mode_hits[0],
                 mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4], mode_hits[5],
                 mode_hits[6], mode_hits[7]);
        if (!timed_out && errors == 0)
            $display("PASS rgba_over_compositor");
        else
            $display("FAIL rgba_over_compositor");
        $finish;
    end

endmodule
